>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the keyer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Types and constants shared by the Morse keyer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mkt_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PHASE_BITS_DEF  = 10;
	localparam int BUF_DEPTH       = 2;

	localparam int CODE_W    = 8;
	localparam int TIMER_W   = 16;
	localparam int UNIT_W    = 13;
	localparam int STEP_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;

	localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 13'd450;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 10'd104;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UNIT_TICKS = 2'd0,
		CFG_PHASE_STEP = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_SYMBOL   = 2'd1,
		KIND_WORD_GAP = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
	} item_t;

endpackage

>>> hw/rtl/mkt_front.sv
// ----------------------------------------------------------------------------
// mkt_front
// Input queue: takes pushes, classifies them, holds them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mkt_front import mkt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic [CODE_W-1:0] symbol_code,
	input  logic              is_word_gap,
	output logic              item_valid,
	output item_t             item,
	input  logic              item_take
);

	localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = $clog2(BUF_DEPTH + 1);

	item_t         buf_q [BUF_DEPTH];
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [CW-1:0] cnt_q;
	item_t         new_item;
	logic          wr;
	logic          rd;

	always_comb begin
		new_item.code = symbol_code;
		if (!action) begin
			new_item.kind = KIND_TICK;
		end else if (is_word_gap) begin
			new_item.kind = KIND_WORD_GAP;
		end else begin
			new_item.kind = KIND_SYMBOL;
		end
	end

	assign full       = (cnt_q == CW'(BUF_DEPTH));
	assign wr         = push && !full;
	assign item_valid = (cnt_q != '0);
	assign item       = buf_q[rd_idx_q];
	assign rd         = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_idx_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_idx_q <= (wr_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (rd) begin
				rd_idx_q <= (rd_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	`ASSERT_NEVER(a_front_cnt_bound, clk, arst_n, cnt_q > CW'(BUF_DEPTH), "front queue over depth")

endmodule

>>> hw/rtl/mkt_back.sv
// ----------------------------------------------------------------------------
// mkt_back
// Keyer engine: symbol ring, element sequencing, tone and silence timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mkt_back import mkt_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [UNIT_W-1:0]     unit_ticks,
	input  logic [STEP_W-1:0]     phase_step,
	input  logic                  item_valid,
	input  item_t                 item,
	output logic                  item_take,
	input  logic                  res_space,
	output logic                  res_valid,
	output logic                  res_tone_on,
	output logic [PHASE_BITS-1:0] res_phase,
	output logic                  res_dropped
);

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int SUM_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
	localparam int ENT_W = CODE_W + 1;

	logic [ENT_W-1:0]      sym_mem_q [QUEUE_DEPTH];
	logic [ENT_W-1:0]      head_q;
	logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
	logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
	logic [AW-1:0]         wr_ptr_nx, rd_ptr_nx;
	logic [TIMER_W-1:0]    tone_cnt_q, tone_cnt_d;
	logic [TIMER_W-1:0]    sil_cnt_q, sil_cnt_d;
	logic [CODE_W-1:0]     pat_q, pat_d, pat_shr;
	logic [PHASE_BITS-1:0] phase_q, phase_d;
	logic [SUM_W-1:0]      phase_sum;
	logic [TIMER_W-1:0]    u1, u3, u7;
	logic [ENT_W-1:0]      wr_word;
	logic                  fire, q_full, q_empty, wr_en, sounding, refused;

	assign fire      = item_valid && res_space;
	assign item_take = fire;

	assign wr_ptr_nx = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nx = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign q_full    = (wr_ptr_nx == rd_ptr_q);
	assign q_empty   = (wr_ptr_q == rd_ptr_q);

	// unit multiples by shift and add or subtract; 7 * 8191 still fits the timer width
	assign u1 = TIMER_W'(unit_ticks);
	assign u3 = u1 + {u1[TIMER_W-2:0], 1'b0};
	assign u7 = {u1[TIMER_W-4:0], 3'b000} - u1;

	assign phase_sum = SUM_W'(phase_q) + SUM_W'(phase_step);
	assign pat_shr   = pat_q >> 1;
	assign wr_word   = {item.kind == KIND_WORD_GAP, item.code};

	always_comb begin
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		tone_cnt_d = tone_cnt_q;
		sil_cnt_d  = sil_cnt_q;
		pat_d      = pat_q;
		phase_d    = phase_q;
		wr_en      = 1'b0;
		sounding   = 1'b0;
		refused    = 1'b0;
		if (fire) begin
			if (item.kind != KIND_TICK) begin
				if (q_full) begin
					refused = 1'b1;
				end else begin
					wr_en    = 1'b1;
					wr_ptr_d = wr_ptr_nx;
				end
			end else if (tone_cnt_q != '0) begin
				phase_d    = phase_sum[PHASE_BITS-1:0];
				tone_cnt_d = tone_cnt_q - 1'b1;
				sounding   = 1'b1;
			end else if (sil_cnt_q != '0) begin
				sil_cnt_d = sil_cnt_q - 1'b1;
			end else if (pat_q != '0) begin
				tone_cnt_d = pat_q[0] ? u3 : u1;
				// last element of a character gets the letter gap
				if (pat_shr == CODE_W'(1)) begin
					sil_cnt_d = u3;
					pat_d     = '0;
				end else begin
					sil_cnt_d = u1;
					pat_d     = pat_shr;
				end
			end else if (!q_empty) begin
				rd_ptr_d = rd_ptr_nx;
				if (head_q[CODE_W]) begin
					sil_cnt_d = u7;
					pat_d     = '0;
				end else if (head_q[CODE_W-1:1] == '0) begin
					pat_d = '0;
				end else begin
					pat_d = head_q[CODE_W-1:0];
				end
			end
		end
	end

	assign res_valid   = fire;
	assign res_tone_on = sounding;
	assign res_phase   = phase_d;
	assign res_dropped = refused;

	// ring storage; head_q tracks the entry at the read pointer, with
	// write-through when the written slot is the one about to be read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_mem_q[wr_ptr_q] <= wr_word;
		end
		if (wr_en && (wr_ptr_q == rd_ptr_d)) begin
			head_q <= wr_word;
		end else begin
			head_q <= sym_mem_q[rd_ptr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			tone_cnt_q <= '0;
			sil_cnt_q  <= '0;
			pat_q      <= '0;
			phase_q    <= '0;
		end else begin
			rd_ptr_q   <= rd_ptr_d;
			wr_ptr_q   <= wr_ptr_d;
			tone_cnt_q <= tone_cnt_d;
			sil_cnt_q  <= sil_cnt_d;
			pat_q      <= pat_d;
			phase_q    <= phase_d;
		end
	end

	`ASSERT_NEVER(a_back_pat_no_sentinel, clk, arst_n, pat_q == CODE_W'(1), "bare sentinel left in pattern")
	`ASSERT_PROP(a_back_push_advances, clk, arst_n, (fire && item.kind != KIND_TICK && !q_full) |=> (wr_ptr_q != $past(wr_ptr_q)), "accepted push did not advance write pointer")
	`ASSERT_PROP(a_back_deq_only_idle, clk, arst_n, (rd_ptr_q != $past(rd_ptr_q)) |-> $past(fire && item.kind == KIND_TICK && tone_cnt_q == '0 && sil_cnt_q == '0 && pat_q == '0), "dequeue while keyer busy")

endmodule

>>> hw/rtl/mkt_res_q.sv
// ----------------------------------------------------------------------------
// mkt_res_q
// Result queue between the keyer engine and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mkt_res_q import mkt_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  logic                  wr_tone_on,
	input  logic [PHASE_BITS-1:0] wr_phase,
	input  logic                  wr_dropped,
	output logic                  space,
	output logic                  empty,
	input  logic                  pop,
	output logic                  tone_on,
	output logic [PHASE_BITS-1:0] phase,
	output logic                  dropped
);

	localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int RW = PHASE_BITS + 2;

	logic [RW-1:0] buf_q [BUF_DEPTH];
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] head;
	logic          rd;

	assign space = (cnt_q != CW'(BUF_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign head  = buf_q[rd_idx_q];

	assign tone_on = head[RW-1];
	assign phase   = head[RW-2:1];
	assign dropped = head[0];

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_idx_q] <= {wr_tone_on, wr_phase, wr_dropped};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_idx_q <= (wr_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (rd) begin
				rd_idx_q <= (rd_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	`ASSERT_NEVER(a_resq_no_overflow, clk, arst_n, wr && cnt_q == CW'(BUF_DEPTH), "result written into full queue")

endmodule

>>> hw/rtl/morse_keyer_tone_timer.sv
// ----------------------------------------------------------------------------
// morse_keyer_tone_timer
// Morse keyer: queued symbols are keyed out as timed tone and silence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): one transaction per item. action=1 queues a
//   symbol (symbol_code, LSB first, 1=dah, sentinel above last element) or a
//   word gap (is_word_gap=1); action=0 is one timer tick.
//   Result channel (empty/pop): exactly one result per input item, in order:
//   tone_on, phase after the item, dropped (push refused, symbol ring full).
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 = unit_ticks,
//   1 = phase_step, other indexes ignored; ready is always high. Write only
//   while the block is idle.
//   Result timing: a result is on the result ports in the cycle after its
//   item is taken, held in the registered result queue.
//   Throughput: one item per cycle while the result queue has room; every
//   item, push or tick, is a single pass through the keyer engine.
//   Reset: all queues empty, timers and phase zero, registers at defaults.
//   Stall: a blocked result side fills the two-entry result queue, then the
//   two-entry input queue, after which full rises; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_keyer_tone_timer import mkt_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item input
	input  logic                  push,
	output logic                  full,
	input  logic                  action,
	input  logic [CODE_W-1:0]     symbol_code,
	input  logic                  is_word_gap,
	// results
	output logic                  empty,
	input  logic                  pop,
	output logic                  tone_on,
	output logic [PHASE_BITS-1:0] phase,
	output logic                  dropped,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	logic [UNIT_W-1:0]     unit_ticks_q;
	logic [STEP_W-1:0]     phase_step_q;
	logic                  item_valid;
	item_t                 item;
	logic                  item_take;
	logic                  res_space;
	logic                  res_valid;
	logic                  res_tone_on;
	logic [PHASE_BITS-1:0] res_phase;
	logic                  res_dropped;

	// register file: always ready, one write per transaction
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RST;
			phase_step_q <= PHASE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_UNIT_TICKS: unit_ticks_q <= cfg_data[UNIT_W-1:0];
				CFG_PHASE_STEP: phase_step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// front: accept and classify
	mkt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.symbol_code (symbol_code),
		.is_word_gap (is_word_gap),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	// back: ring, sequencing, timers; fires when an item waits and the result queue has room
	mkt_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PHASE_BITS  (PHASE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.unit_ticks  (unit_ticks_q),
		.phase_step  (phase_step_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.res_space   (res_space),
		.res_valid   (res_valid),
		.res_tone_on (res_tone_on),
		.res_phase   (res_phase),
		.res_dropped (res_dropped)
	);

	// result queue decouples the engine from a stalled consumer
	mkt_res_q #(
		.PHASE_BITS (PHASE_BITS)
	) u_res_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (res_valid),
		.wr_tone_on (res_tone_on),
		.wr_phase   (res_phase),
		.wr_dropped (res_dropped),
		.space      (res_space),
		.empty      (empty),
		.pop        (pop),
		.tone_on    (tone_on),
		.phase      (phase),
		.dropped    (dropped)
	);

endmodule
